FILE: hw/rtl/lcom_pkg.sv
// ----------------------------------------------------------------------------
// lcom_pkg
// Shared constants, types and register codes of the curvature and occlusion
// marker.
// ----------------------------------------------------------------------------
package lcom_pkg;

    localparam int HALF_WINDOW = 5;
    localparam int WIN_DEPTH   = 2 * HALF_WINDOW + 2;
    localparam int SPAN        = 2 * HALF_WINDOW + 1;

    localparam int RANGE_W = 16;
    localparam int COL_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CNT_W   = 16;
    localparam int CURV_W  = 39;
    localparam int CIDX_W  = 2;

    localparam int SUM_W  = $clog2(SPAN * 65536);
    localparam int MAG_W  = $clog2(2 * HALF_WINDOW * 65536);
    localparam int SQ_W   = 2 * MAG_W;
    localparam int EXT_W  = (SQ_W > CURV_W) ? SQ_W : CURV_W;
    localparam int IDX_W  = $clog2(WIN_DEPTH);
    localparam int PEND_W = $clog2(HALF_WINDOW + 1);

    localparam logic [IDX_W-1:0]  Q_FIRST  = IDX_W'(HALF_WINDOW);
    localparam logic [IDX_W-1:0]  Q_SECOND = IDX_W'(HALF_WINDOW + 1);
    localparam logic [IDX_W-1:0]  Q_LAST   = IDX_W'(WIN_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [CURV_W-1:0] CURV_LIMIT = '1;

    localparam logic [CIDX_W-1:0] CFG_OCCLUSION_GAP    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PARALLEL_RATIO   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COLUMN_GAP_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] OCCLUSION_GAP_RST    = 16'd77;
    localparam logic [CFG_W-1:0] PARALLEL_RATIO_RST   = 16'd1311;
    localparam logic [CFG_W-1:0] COLUMN_GAP_LIMIT_RST = 16'd10;

    typedef struct packed {
        logic [RANGE_W-1:0] rng;
        logic [COL_W-1:0]   col;
        logic               excl;
    } point_t;

    typedef struct packed {
        logic             shift;
        logic             clear;
        logic             s1_load;
        logic             out_load;
        logic [IDX_W-1:0] q;
        logic             pt_valid;
        logic             last;
    } curv_ctl_t;

endpackage

FILE: hw/rtl/lidar_curvature_occlusion_marker.sv
// ----------------------------------------------------------------------------
// lidar_curvature_occlusion_marker
// Scan curvature and exclusion marking over a sliding point window held in a
// row of cells.
//
//   channel  dir  handshake            beat contents
//   in       in   in_valid/in_ready    range, column, last_point
//   out      out  out_valid/out_ready  curvature, curvature_valid, excluded,
//                                      last_result
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One input point per cycle while in_ready is high. A last_point beat drains
// the scan tail: up to seven results, one per cycle from the center-select
// counter while the output is not stalled, with in_ready low until the last
// one enters the pipeline; the window then clears. Output stalls back up
// through the difference and square stages before in_ready drops. cfg_ready
// is always high. Reset is asynchronous and clears the window and the counters.
// ----------------------------------------------------------------------------
module lidar_curvature_occlusion_marker
    import lcom_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [RANGE_W-1:0] range,
    input  logic [COL_W-1:0]   column,
    input  logic               last_point,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [CURV_W-1:0]  curvature,
    output logic               curvature_valid,
    output logic               excluded,
    output logic               last_result,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic [CFG_W-1:0] occlusion_gap_reg;
    logic [CFG_W-1:0] parallel_ratio_reg;
    logic [CFG_W-1:0] column_gap_limit_reg;

    logic             req_reg;
    logic             req_next;
    logic             flush_reg;
    logic             flush_next;
    logic [IDX_W-1:0] q_reg;
    logic [IDX_W-1:0] q_next;
    logic             vfirst_reg;
    logic             vfirst_next;
    logic             vsecond_reg;
    logic             vsecond_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic             out_en;
    logic             s1_en;
    logic             req_take;
    logic             accept;
    logic             clear;
    logic [IDX_W-1:0] q_start;

    logic [WIN_DEPTH-1:0] mark;
    logic [CNT_W-1:0]     points;
    point_t               cells [WIN_DEPTH];
    point_t               feeds [WIN_DEPTH];
    curv_ctl_t            ctl;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occlusion_gap_reg    <= OCCLUSION_GAP_RST;
            parallel_ratio_reg   <= PARALLEL_RATIO_RST;
            column_gap_limit_reg <= COLUMN_GAP_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OCCLUSION_GAP:    occlusion_gap_reg    <= cfg_data;
                CFG_PARALLEL_RATIO:   parallel_ratio_reg   <= cfg_data;
                CFG_COLUMN_GAP_LIMIT: column_gap_limit_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // handshake and drain control
    always_comb
    begin
        out_en   = !out_valid_reg || out_ready;
        s1_en    = !s1_valid_reg || out_en;
        req_take = req_reg && s1_en;
        in_ready = !flush_reg && (!req_reg || s1_en);
        accept   = in_valid && in_ready;
        clear    = req_take && flush_reg && (q_reg == Q_LAST);
        q_start  = (points >= CNT_W'(HALF_WINDOW + 1))
                   ? Q_FIRST : IDX_W'(CNT_W'(WIN_DEPTH - 1) - points);
    end

    always_comb
    begin
        req_next       = req_reg;
        flush_next     = flush_reg;
        q_next         = q_reg;
        vfirst_next    = vfirst_reg;
        vsecond_next   = vsecond_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;

        if (req_take)
        begin
            if (flush_reg && (q_reg != Q_LAST))
            begin
                q_next = q_reg + 1'b1;
            end
            else
            begin
                req_next   = 1'b0;
                flush_next = 1'b0;
            end
        end
        if (accept)
        begin
            req_next     = last_point || (points >= CNT_W'(HALF_WINDOW + 1));
            flush_next   = last_point;
            q_next       = last_point ? q_start : Q_FIRST;
            vfirst_next  = points >= CNT_W'(2 * HALF_WINDOW + 1);
            vsecond_next = points >= CNT_W'(2 * HALF_WINDOW);
        end
        if (s1_en)
        begin
            s1_valid_next = req_reg;
        end
        if (out_en)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg       <= 1'b0;
            flush_reg     <= 1'b0;
            q_reg         <= Q_FIRST;
            vfirst_reg    <= 1'b0;
            vsecond_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_reg       <= req_next;
            flush_reg     <= flush_next;
            q_reg         <= q_next;
            vfirst_reg    <= vfirst_next;
            vsecond_reg   <= vsecond_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // window cells
    genvar k;
    generate
        for (k = 0; k < WIN_DEPTH; k++)
        begin : g_cell
            if (k == WIN_DEPTH - 1)
            begin : g_head
                assign feeds[k] = '{rng: range, col: column, excl: 1'b0};
            end
            else
            begin : g_body
                assign feeds[k] = cells[k+1];
            end

            lcom_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (accept),
                .clear (clear),
                .mark  (mark[k]),
                .feed  (feeds[k]),
                .slot  (cells[k])
            );
        end
    endgenerate

    lcom_mark u_mark (
        .clk              (clk),
        .rst_n            (rst_n),
        .shift            (accept),
        .clear            (clear),
        .range_in         (range),
        .column_in        (column),
        .newest           (cells[WIN_DEPTH-1]),
        .prev             (cells[WIN_DEPTH-2]),
        .occlusion_gap    (occlusion_gap_reg),
        .parallel_ratio   (parallel_ratio_reg),
        .column_gap_limit (column_gap_limit_reg),
        .mark             (mark),
        .points           (points)
    );

    always_comb
    begin
        ctl.shift    = accept;
        ctl.clear    = clear;
        ctl.s1_load  = s1_en;
        ctl.out_load = out_en;
        ctl.q        = q_reg;
        ctl.pt_valid = ((q_reg == Q_FIRST) && vfirst_reg) || ((q_reg == Q_SECOND) && vsecond_reg);
        ctl.last     = flush_reg && (q_reg == Q_LAST);
    end

    lcom_curv u_curv (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cells           (cells),
        .range_in        (range),
        .curvature       (curvature),
        .curvature_valid (curvature_valid),
        .excluded        (excluded),
        .last_result     (last_result)
    );

endmodule

FILE: hw/rtl/lcom_cell.sv
// ----------------------------------------------------------------------------
// lcom_cell
// One window slot: holds range, column and exclusion flag of one point and
// takes its neighbor's point on every shift.
// ----------------------------------------------------------------------------
module lcom_cell
    import lcom_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  logic   clear,
    input  logic   mark,
    input  point_t feed,
    output point_t slot
);

    point_t slot_reg;
    point_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (clear)
        begin
            slot_next = '0;
        end
        else if (shift)
        begin
            slot_next      = feed;
            slot_next.excl = feed.excl | mark;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

FILE: hw/rtl/lcom_mark.sv
// ----------------------------------------------------------------------------
// lcom_mark
// Occlusion and parallel-beam rules on the newest pair, forward mark
// countdown and point counter.
// ----------------------------------------------------------------------------
module lcom_mark
    import lcom_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 clear,
    input  logic [RANGE_W-1:0]   range_in,
    input  logic [COL_W-1:0]     column_in,
    input  point_t               newest,
    input  point_t               prev,
    input  logic [CFG_W-1:0]     occlusion_gap,
    input  logic [CFG_W-1:0]     parallel_ratio,
    input  logic [CFG_W-1:0]     column_gap_limit,
    output logic [WIN_DEPTH-1:0] mark,
    output logic [CNT_W-1:0]     points
);

    logic [PEND_W-1:0]  pend_reg;
    logic [PEND_W-1:0]  pend_next;
    logic [CNT_W-1:0]   points_reg;
    logic [CNT_W-1:0]   points_next;

    logic               pair_ok;
    logic [COL_W-1:0]   col_diff;
    logic               col_near;
    logic               back_hit;
    logic               fwd_hit;
    logic [RANGE_W-1:0] diff_a;
    logic [RANGE_W-1:0] diff_b;
    logic [31:0]        lim;
    logic               par_hit;

    always_comb
    begin
        pair_ok  = points_reg >= CNT_W'(HALF_WINDOW + 1);
        col_diff = (column_in > newest.col) ? column_in - newest.col : newest.col - column_in;
        col_near = col_diff < column_gap_limit;
        back_hit = pair_ok && col_near && (newest.rng > range_in)
                   && ((newest.rng - range_in) > occlusion_gap);
        fwd_hit  = pair_ok && col_near && (range_in > newest.rng)
                   && ((range_in - newest.rng) > occlusion_gap);
        diff_a   = (prev.rng > newest.rng) ? prev.rng - newest.rng : newest.rng - prev.rng;
        diff_b   = (range_in > newest.rng) ? range_in - newest.rng : newest.rng - range_in;
        lim      = 32'(parallel_ratio) * 32'(newest.rng);
        par_hit  = pair_ok && ({diff_a, 16'd0} > lim) && ({diff_b, 16'd0} > lim);

        mark = '0;
        for (int k = HALF_WINDOW; k <= WIN_DEPTH - 2; k++)
        begin
            mark[k] = back_hit;
        end
        mark[WIN_DEPTH-2] = back_hit | par_hit;
        mark[WIN_DEPTH-1] = (pend_reg != '0) | fwd_hit;
    end

    always_comb
    begin
        pend_next   = pend_reg;
        points_next = points_reg;
        if (clear)
        begin
            pend_next   = '0;
            points_next = '0;
        end
        else if (shift)
        begin
            if (fwd_hit)
            begin
                pend_next = PEND_W'(HALF_WINDOW);
            end
            else if (pend_reg != '0)
            begin
                pend_next = pend_reg - 1'b1;
            end
            if (points_reg != CNT_MAX)
            begin
                points_next = points_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= '0;
            points_reg <= '0;
        end
        else
        begin
            pend_reg   <= pend_next;
            points_reg <= points_next;
        end
    end

    assign points = points_reg;

endmodule

FILE: hw/rtl/lcom_curv.sv
// ----------------------------------------------------------------------------
// lcom_curv
// Running window sums, center difference stage and squaring output stage.
// ----------------------------------------------------------------------------
module lcom_curv
    import lcom_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  curv_ctl_t          ctl,
    input  point_t             cells [WIN_DEPTH],
    input  logic [RANGE_W-1:0] range_in,
    output logic [CURV_W-1:0]  curvature,
    output logic               curvature_valid,
    output logic               excluded,
    output logic               last_result
);

    logic [SUM_W-1:0]   sum_a_reg;
    logic [SUM_W-1:0]   sum_a_next;
    logic [SUM_W-1:0]   sum_b_reg;
    logic [SUM_W-1:0]   sum_b_next;

    logic [SUM_W-1:0]   sel_sum;
    logic [RANGE_W-1:0] center;
    logic [SUM_W-1:0]   center_x;
    logic [SUM_W:0]     diff;
    logic [SUM_W:0]     diff_abs;

    logic [MAG_W-1:0]   mag_reg;
    logic               valid_s1_reg;
    logic               excl_s1_reg;
    logic               last_s1_reg;

    logic [SQ_W-1:0]    sq;
    logic [EXT_W-1:0]   sq_ext;
    logic [CURV_W-1:0]  curv_sat;

    logic [CURV_W-1:0]  curv_reg;
    logic               valid_reg;
    logic               excl_reg;
    logic               last_reg;

    always_comb
    begin
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        if (ctl.clear)
        begin
            sum_a_next = '0;
            sum_b_next = '0;
        end
        else if (ctl.shift)
        begin
            sum_a_next = sum_a_reg - SUM_W'(cells[0].rng) + SUM_W'(cells[WIN_DEPTH-1].rng);
            sum_b_next = sum_b_reg - SUM_W'(cells[1].rng) + SUM_W'(range_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end
        else
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    always_comb
    begin
        sel_sum  = (ctl.q == Q_SECOND) ? sum_b_reg : sum_a_reg;
        center   = (ctl.q == Q_SECOND) ? cells[HALF_WINDOW+1].rng : cells[HALF_WINDOW].rng;
        center_x = SUM_W'(center) * SUM_W'(SPAN);
        diff     = {1'b0, sel_sum} - {1'b0, center_x};
        diff_abs = diff[SUM_W] ? (~diff + 1'b1) : diff;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            mag_reg      <= ctl.pt_valid ? diff_abs[MAG_W-1:0] : '0;
            valid_s1_reg <= ctl.pt_valid;
            excl_s1_reg  <= !ctl.pt_valid || cells[ctl.q].excl;
            last_s1_reg  <= ctl.last;
        end
    end

    always_comb
    begin
        sq       = SQ_W'(mag_reg) * SQ_W'(mag_reg);
        sq_ext   = EXT_W'(sq);
        curv_sat = (sq_ext > EXT_W'(CURV_LIMIT)) ? CURV_LIMIT : sq_ext[CURV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            curv_reg  <= curv_sat;
            valid_reg <= valid_s1_reg;
            excl_reg  <= excl_s1_reg;
            last_reg  <= last_s1_reg;
        end
    end

    assign curvature       = curv_reg;
    assign curvature_valid = valid_reg;
    assign excluded        = excl_reg;
    assign last_result     = last_reg;

endmodule
